### hdl/ctpg_pkg.sv
// Shared types, constants and update functions for the combined Tausworthe generator.
// No dependencies; used by ctpg_lfsr, ctpg_mul and combined_tausworthe_prng.
`default_nettype none

package ctpg_pkg;

    // Width of one generator component word.
    localparam int WORD_BITS = 64;
    // Width of the uniform fraction taken from the low bits of the mixed word.
    localparam int FRAC_BITS = 52;
    // Width of the range bounds and the scaled result.
    localparam int INT_BITS = 32;
    // Width of a range span, which can reach 2^32.
    localparam int SPAN_BITS = INT_BITS + 1;
    // Number of seed registers and the width of their index.
    localparam int NUM_SEEDS = 4;
    localparam int CFG_INDEX_BITS = 2;

    // Shift triples (k, q, s) of the four components.
    localparam int K0 = 63;
    localparam int Q0 = 31;
    localparam int S0 = 18;
    localparam int K1 = 58;
    localparam int Q1 = 19;
    localparam int S1 = 28;
    localparam int K2 = 55;
    localparam int Q2 = 24;
    localparam int S2 = 7;
    localparam int K3 = 47;
    localparam int Q3 = 21;
    localparam int S3 = 8;

    // Request modes.
    localparam logic [1:0] MODE_FRACTION = 2'd0;
    localparam logic [1:0] MODE_BOUNDED  = 2'd1;
    localparam logic [1:0] MODE_RANGE    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_ZERO  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_ONE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_TWO   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_THREE = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WARM,
        ST_DRAW,
        ST_CALC,
        ST_SCALE,
        ST_EMIT
    } ctpg_state_t;

    // Commands from the sequencer to the component bank.
    typedef struct packed {
        logic load;
        logic step;
    } ctpg_lfsr_cmd_t;

    // One Tausworthe step of a component word; k, q and s are constants at each call.
    function automatic logic [WORD_BITS-1:0] tw_update(
        input logic [WORD_BITS-1:0] z,
        input int k,
        input int q,
        input int s
    );
        logic [WORD_BITS-1:0] keep;
        keep = z & ({WORD_BITS{1'b1}} << (WORD_BITS - k));
        return (((z << q) ^ z) >> (k - s)) ^ (keep << s);
    endfunction

    // A seed word below 2^(64-k) would leave the component degenerate: lift it.
    function automatic logic [WORD_BITS-1:0] apply_floor(
        input logic [WORD_BITS-1:0] w,
        input int k
    );
        logic [WORD_BITS-1:0] floor_val;
        floor_val = {{(WORD_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - k);
        return (w < floor_val) ? (w + floor_val) : w;
    endfunction

endpackage

`default_nettype wire

### hdl/ctpg_lfsr.sv
// Seed registers and the four generator components, advanced one step per command.
// Depends on ctpg_pkg for the shift triples, the update functions and the command struct.
`default_nettype none

module ctpg_lfsr
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [ctpg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ctpg_pkg::WORD_BITS-1:0]         cfg_data,
    input  wire ctpg_pkg::ctpg_lfsr_cmd_t               cmd,
    output logic [ctpg_pkg::WORD_BITS-1:0]              mix
);

    logic [ctpg_pkg::WORD_BITS-1:0] seed_reg [ctpg_pkg::NUM_SEEDS];
    logic [ctpg_pkg::WORD_BITS-1:0] comp0_reg;
    logic [ctpg_pkg::WORD_BITS-1:0] comp1_reg;
    logic [ctpg_pkg::WORD_BITS-1:0] comp2_reg;
    logic [ctpg_pkg::WORD_BITS-1:0] comp3_reg;
    logic [ctpg_pkg::WORD_BITS-1:0] comp0_next;
    logic [ctpg_pkg::WORD_BITS-1:0] comp1_next;
    logic [ctpg_pkg::WORD_BITS-1:0] comp2_next;
    logic [ctpg_pkg::WORD_BITS-1:0] comp3_next;

    // Seed words are written by the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctpg_pkg::NUM_SEEDS; i++)
            begin
                seed_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            seed_reg[cfg_index] <= cfg_data;
        end
    end

    // Load floored seeds or take one shared update step of all four components.
    always_comb
    begin
        comp0_next = comp0_reg;
        comp1_next = comp1_reg;
        comp2_next = comp2_reg;
        comp3_next = comp3_reg;
        if (cmd.load)
        begin
            comp0_next = ctpg_pkg::apply_floor(seed_reg[ctpg_pkg::REG_SEED_ZERO], ctpg_pkg::K0);
            comp1_next = ctpg_pkg::apply_floor(seed_reg[ctpg_pkg::REG_SEED_ONE], ctpg_pkg::K1);
            comp2_next = ctpg_pkg::apply_floor(seed_reg[ctpg_pkg::REG_SEED_TWO], ctpg_pkg::K2);
            comp3_next = ctpg_pkg::apply_floor(seed_reg[ctpg_pkg::REG_SEED_THREE],
                                               ctpg_pkg::K3);
        end
        else if (cmd.step)
        begin
            comp0_next = ctpg_pkg::tw_update(comp0_reg, ctpg_pkg::K0, ctpg_pkg::Q0,
                                             ctpg_pkg::S0);
            comp1_next = ctpg_pkg::tw_update(comp1_reg, ctpg_pkg::K1, ctpg_pkg::Q1,
                                             ctpg_pkg::S1);
            comp2_next = ctpg_pkg::tw_update(comp2_reg, ctpg_pkg::K2, ctpg_pkg::Q2,
                                             ctpg_pkg::S2);
            comp3_next = ctpg_pkg::tw_update(comp3_reg, ctpg_pkg::K3, ctpg_pkg::Q3,
                                             ctpg_pkg::S3);
        end
    end

    // Component registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp0_reg <= '0;
            comp1_reg <= '0;
            comp2_reg <= '0;
            comp3_reg <= '0;
        end
        else
        begin
            comp0_reg <= comp0_next;
            comp1_reg <= comp1_next;
            comp2_reg <= comp2_next;
            comp3_reg <= comp3_next;
        end
    end

    // The combined output is the xor of the current component words.
    assign mix = comp0_reg ^ comp1_reg ^ comp2_reg ^ comp3_reg;

endmodule

`default_nettype wire

### hdl/ctpg_mul.sv
// Bit-serial shift-add multiplier giving floor(fr * span / 2^FR_BITS).
// Depends on ctpg_pkg for the span width.
`default_nettype none

module ctpg_mul
#(
    parameter int FR_BITS = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [FR_BITS-1:0]                 fr,
    input  wire logic [ctpg_pkg::SPAN_BITS-1:0]     span,
    output logic                                    done,
    output logic [ctpg_pkg::SPAN_BITS-1:0]          product_hi
);

    localparam int CNT_BITS = (FR_BITS > 1) ? $clog2(FR_BITS) : 1;

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [CNT_BITS-1:0]                cnt_reg;
    logic [CNT_BITS-1:0]                cnt_next;
    logic [ctpg_pkg::SPAN_BITS-1:0]     acc_reg;
    logic [ctpg_pkg::SPAN_BITS-1:0]     acc_next;
    logic [FR_BITS-1:0]                 mq_reg;
    logic [FR_BITS-1:0]                 mq_next;
    logic [ctpg_pkg::SPAN_BITS-1:0]     span_reg;
    logic [ctpg_pkg::SPAN_BITS-1:0]     span_next;
    logic [ctpg_pkg::SPAN_BITS:0]       sum;

    // One multiplier bit per cycle: add span into the high half, then shift right.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mq_next   = mq_reg;
        span_next = span_reg;
        sum       = {1'b0, acc_reg} + (mq_reg[0] ? {1'b0, span_reg} : '0);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mq_next   = fr;
            span_next = span;
        end
        else if (busy_reg)
        begin
            acc_next = sum[ctpg_pkg::SPAN_BITS:1];
            mq_next  = {sum[0], mq_reg[FR_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(FR_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mq_reg   <= mq_next;
        span_reg <= span_next;
    end

    assign done       = done_reg;
    assign product_hi = acc_reg;

endmodule

`default_nettype wire

### hdl/combined_tausworthe_prng.sv
// Top level of the combined four-component Tausworthe generator (period 2^223).
// Depends on ctpg_pkg, ctpg_lfsr and ctpg_mul.
//
// Usage: each transfer on the s_axis channel requests one draw; its tuser carries
// the mode and its tdata the range bounds. Each draw returns exactly one transfer on
// m_axis carrying the 52-bit fraction, the scaled value and the empty-range flag.
// The cfg channel writes the four seed words (index 0 to 3); any write makes the
// next draw reload the seeds, lift each below its floor, and run WARMUP_STEPS
// silent updates. cfg_ready is always high; writes belong between draws.
// Each draw runs the sequencer through LOAD and WARM (first draw after reset or a seed
// write only), then DRAW and CALC, then SCALE when a nonempty range is scaled, then
// EMIT; fraction mode and an empty range skip SCALE. The scaling multiplier retires
// one bit of the fraction per cycle. One draw is in flight at a time: s_axis_tready is
// high only while the sequencer is idle, so a new draw can be accepted in the cycle after
// the previous result is handed to the output register.
// Reset clears the seeds, the components and the seeded flag, and drops all valids.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its finished result until that register frees up.
`default_nettype none

module combined_tausworthe_prng
#(
    parameter int RANGE_BITS   = 32,
    parameter int WARMUP_STEPS = 10
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Requests.
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [63:0]                            s_axis_tdata,  // range_a, range_b
    input  wire logic [1:0]                             s_axis_tuser,  // mode
    // Results.
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [87:0]                                 m_axis_tdata,  // fraction, value, pad
    output logic [0:0]                                  m_axis_tuser,  // range_empty
    // Seed writes.
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ctpg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ctpg_pkg::WORD_BITS-1:0]         cfg_data
);

    localparam int WARM_CNT_BITS = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;
    localparam int PAD_BITS = 88 - ctpg_pkg::FRAC_BITS - ctpg_pkg::INT_BITS;

    ctpg_pkg::ctpg_state_t                  state_reg;
    ctpg_pkg::ctpg_state_t                  state_next;
    logic                                   seeded_reg;
    logic                                   seeded_next;
    logic [WARM_CNT_BITS-1:0]               warm_cnt_reg;
    logic [WARM_CNT_BITS-1:0]               warm_cnt_next;
    logic                                   m_valid_reg;
    logic                                   m_valid_next;

    logic [1:0]                             mode_reg;
    logic signed [ctpg_pkg::INT_BITS-1:0]   a_reg;
    logic signed [ctpg_pkg::INT_BITS-1:0]   b_reg;
    logic [ctpg_pkg::FRAC_BITS-1:0]         frac_reg;
    logic [ctpg_pkg::INT_BITS-1:0]          low_reg;
    logic                                   empty_reg;
    logic [ctpg_pkg::INT_BITS-1:0]          res_value_reg;
    logic [ctpg_pkg::FRAC_BITS-1:0]         out_frac_reg;
    logic [ctpg_pkg::INT_BITS-1:0]          out_value_reg;
    logic                                   out_empty_reg;

    ctpg_pkg::ctpg_lfsr_cmd_t               lfsr_cmd;
    logic [ctpg_pkg::WORD_BITS-1:0]         mix;
    logic                                   cfg_we;
    logic                                   in_xfer;
    logic                                   mul_start;
    logic                                   mul_done;
    logic [ctpg_pkg::SPAN_BITS-1:0]         product_hi;

    logic                                   is_int;
    logic signed [ctpg_pkg::INT_BITS-1:0]   lo_sel;
    logic signed [ctpg_pkg::INT_BITS-1:0]   hi_sel;
    logic                                   is_empty;
    logic [ctpg_pkg::SPAN_BITS-1:0]         span;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_xfer   = s_axis_tvalid & s_axis_tready;

    // Component bank.
    ctpg_lfsr u_lfsr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (lfsr_cmd),
        .mix       (mix)
    );

    // Range bounds and span from the latched request.
    always_comb
    begin
        is_int   = (mode_reg == ctpg_pkg::MODE_BOUNDED) || (mode_reg == ctpg_pkg::MODE_RANGE);
        lo_sel   = (mode_reg == ctpg_pkg::MODE_RANGE) ? a_reg : 32'sd1;
        hi_sel   = (mode_reg == ctpg_pkg::MODE_RANGE) ? b_reg : a_reg;
        is_empty = is_int && (hi_sel < lo_sel);
        span     = {hi_sel[ctpg_pkg::INT_BITS-1], hi_sel}
                 - {lo_sel[ctpg_pkg::INT_BITS-1], lo_sel} + 1'b1;
    end

    // Serial scaling multiplier on the top RANGE_BITS bits of the fraction field of the freshly drawn word.
    ctpg_mul
    #(
        .FR_BITS (RANGE_BITS)
    )
    u_mul
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start),
        .fr         (mix[ctpg_pkg::FRAC_BITS-1 -: RANGE_BITS]),
        .span       (span),
        .done       (mul_done),
        .product_hi (product_hi)
    );

    // Sequencer: next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        seeded_next   = seeded_reg;
        warm_cnt_next = warm_cnt_reg;
        m_valid_next  = m_valid_reg;
        lfsr_cmd      = '0;
        mul_start     = 1'b0;
        s_axis_tready = 1'b0;

        // The output register frees up when its transfer completes.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ctpg_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = seeded_reg ? ctpg_pkg::ST_DRAW : ctpg_pkg::ST_LOAD;
                end
            end
            ctpg_pkg::ST_LOAD:
            begin
                lfsr_cmd.load = 1'b1;
                seeded_next   = 1'b1;
                warm_cnt_next = '0;
                state_next    = (WARMUP_STEPS == 0) ? ctpg_pkg::ST_DRAW : ctpg_pkg::ST_WARM;
            end
            ctpg_pkg::ST_WARM:
            begin
                lfsr_cmd.step = 1'b1;
                warm_cnt_next = warm_cnt_reg + 1'b1;
                if (warm_cnt_reg == WARM_CNT_BITS'(WARMUP_STEPS - 1))
                begin
                    state_next = ctpg_pkg::ST_DRAW;
                end
            end
            ctpg_pkg::ST_DRAW:
            begin
                lfsr_cmd.step = 1'b1;
                state_next    = ctpg_pkg::ST_CALC;
            end
            ctpg_pkg::ST_CALC:
            begin
                if (is_int && !is_empty)
                begin
                    mul_start  = 1'b1;
                    state_next = ctpg_pkg::ST_SCALE;
                end
                else
                begin
                    state_next = ctpg_pkg::ST_EMIT;
                end
            end
            ctpg_pkg::ST_SCALE:
            begin
                if (mul_done)
                begin
                    state_next = ctpg_pkg::ST_EMIT;
                end
            end
            ctpg_pkg::ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ctpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctpg_pkg::ST_IDLE;
            end
        endcase

        // A seed write forces a reload on the next draw.
        if (cfg_we)
        begin
            seeded_next = 1'b0;
        end
    end

    // Sequencer and output control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ctpg_pkg::ST_IDLE;
            seeded_reg   <= 1'b0;
            warm_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            warm_cnt_reg <= warm_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Request, working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= s_axis_tuser;
            a_reg    <= s_axis_tdata[31:0];
            b_reg    <= s_axis_tdata[63:32];
        end
        // The components have just stepped, so the mixed word is this draw.
        if (state_reg == ctpg_pkg::ST_CALC)
        begin
            frac_reg      <= mix[ctpg_pkg::FRAC_BITS-1:0];
            low_reg       <= lo_sel;
            empty_reg     <= is_empty;
            res_value_reg <= '0;
        end
        if (state_reg == ctpg_pkg::ST_SCALE && mul_done)
        begin
            res_value_reg <= low_reg + product_hi[ctpg_pkg::INT_BITS-1:0];
        end
        if (state_reg == ctpg_pkg::ST_EMIT && (!m_valid_reg || m_axis_tready))
        begin
            out_frac_reg  <= frac_reg;
            out_value_reg <= res_value_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, out_value_reg, out_frac_reg};
    assign m_axis_tuser  = out_empty_reg;

endmodule

`default_nettype wire
